>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile away under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define GCBP_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("gcbp assertion failed");

// Condition must never be true outside reset
`define GCBP_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("gcbp forbidden condition seen");

`else

`define GCBP_ASSERT(label, clk, rstn, prop)
`define GCBP_NEVER(label, clk, rstn, cond)

`endif

`endif

>>> src/gcbp_pkg.sv
// ---------------------------------------------------------------------------
// gcbp_pkg
// Types, codes and widths shared by the gamma code bit packer modules.
// ---------------------------------------------------------------------------
package gcbp_pkg;

    localparam int MAX_EXPONENT_DEFAULT = 32;
    localparam int VALUE_W              = 32;
    localparam int BYTE_W               = 8;
    localparam int OUT_VALUE_W          = 33;
    localparam int LEN_W                = 7;
    localparam int EXP_W                = $clog2(VALUE_W + 1);
    localparam int REM_ACC_W            = 32;

    // Input item kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Result kinds
    localparam logic [1:0] RK_BYTE  = 2'd0;
    localparam logic [1:0] RK_VALUE = 2'd1;
    localparam logic [1:0] RK_ERROR = 2'd2;

    // Direction register values
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Work handed from front to back
    typedef enum logic [2:0] {
        OP_ENCODE,
        OP_ERROR,
        OP_ENC_FLUSH,
        OP_DEC_FLUSH,
        OP_DECODE
    } op_t;

    typedef struct packed {
        logic                kind;
        logic [VALUE_W-1:0]  value;
        logic [BYTE_W-1:0]   in_byte;
    } in_t;

    typedef struct packed {
        logic [1:0]             result_kind;
        logic [BYTE_W-1:0]      out_byte;
        logic [OUT_VALUE_W-1:0] out_value;
        logic [LEN_W-1:0]       code_length;
        logic                   last;
    } out_t;

    typedef struct packed {
        op_t                 op;
        logic [EXP_W-1:0]    e;
        logic [VALUE_W-1:0]  norm;
        logic [BYTE_W-1:0]   in_byte;
    } cmd_t;

endpackage

>>> src/gcbp_front.sv
// ---------------------------------------------------------------------------
// gcbp_front
// Accepts input items, holds the direction register, classifies each item
// and finds the exponent of encode values with a nibble-step normalizer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gcbp_front #(
    parameter int MAX_EXPONENT = gcbp_pkg::MAX_EXPONENT_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic            cfg_wdata,
    input  logic            s_valid,
    output logic            s_ready,
    input  gcbp_pkg::in_t   s_data,
    output logic            cmd_valid,
    input  logic            cmd_ready,
    output gcbp_pkg::cmd_t  cmd
);

    localparam int VW = gcbp_pkg::VALUE_W;
    localparam int EW = gcbp_pkg::EXP_W;

    typedef enum logic {
        F_IDLE,
        F_NORM
    } fstate_t;

    fstate_t           state_reg, state_next;
    logic              dir_reg, dir_next;
    logic              cmd_valid_reg, cmd_valid_next;
    gcbp_pkg::cmd_t    cmd_reg, cmd_next;
    logic [VW-1:0]     acc_reg, acc_next;
    logic [EW-1:0]     e_reg, e_next;

    logic              accept;
    logic [1:0]        lz;
    logic [EW-1:0]     e_fin;
    logic [VW-1:0]     acc_fin;

    assign s_ready   = (state_reg == F_IDLE) && !cmd_valid_reg;
    assign accept    = s_valid && s_ready;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    // Leading zeros within the top nibble once it is nonzero
    always_comb begin
        if (acc_reg[VW-1]) begin
            lz = 2'd0;
        end else if (acc_reg[VW-2]) begin
            lz = 2'd1;
        end else if (acc_reg[VW-3]) begin
            lz = 2'd2;
        end else begin
            lz = 2'd3;
        end
        acc_fin = acc_reg << lz;
        e_fin   = e_reg - EW'(lz);
    end

    // Classify and normalize
    always_comb begin
        state_next     = state_reg;
        dir_next       = dir_reg;
        cmd_valid_next = cmd_valid_reg;
        cmd_next       = cmd_reg;
        acc_next       = acc_reg;
        e_next         = e_reg;

        if (cmd_valid_reg && cmd_ready) begin
            cmd_valid_next = 1'b0;
        end
        if (cfg_we) begin
            dir_next = cfg_wdata;
        end

        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    cmd_next.in_byte = s_data.in_byte;
                    cmd_next.norm    = '0;
                    cmd_next.e       = '0;
                    if (s_data.kind == gcbp_pkg::KIND_END) begin
                        cmd_next.op    = (dir_reg == gcbp_pkg::DIR_DECODE) ?
                                         gcbp_pkg::OP_DEC_FLUSH : gcbp_pkg::OP_ENC_FLUSH;
                        cmd_valid_next = 1'b1;
                    end else if (dir_reg == gcbp_pkg::DIR_DECODE) begin
                        cmd_next.op    = gcbp_pkg::OP_DECODE;
                        cmd_valid_next = 1'b1;
                    end else if (s_data.value == '0) begin
                        cmd_next.op    = gcbp_pkg::OP_ERROR;
                        cmd_valid_next = 1'b1;
                    end else begin
                        acc_next   = s_data.value;
                        e_next     = EW'(VW);
                        state_next = F_NORM;
                    end
                end
            end
            F_NORM: begin
                if (acc_reg[VW-1 -: 4] == 4'd0) begin
                    // coarse step: skip a zero nibble
                    acc_next = acc_reg << 4;
                    e_next   = e_reg - EW'(4);
                end else begin
                    cmd_next.e     = e_fin;
                    cmd_next.norm  = acc_fin;
                    cmd_next.op    = (e_fin > EW'(MAX_EXPONENT)) ?
                                     gcbp_pkg::OP_ERROR : gcbp_pkg::OP_ENCODE;
                    cmd_valid_next = 1'b1;
                    state_next     = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= F_IDLE;
            dir_reg       <= gcbp_pkg::DIR_ENCODE;
            cmd_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            dir_reg       <= dir_next;
            cmd_valid_reg <= cmd_valid_next;
        end
        cmd_reg <= cmd_next;
        acc_reg <= acc_next;
        e_reg   <= e_next;
    end

    // Normalizer always works on a nonzero value
    `GCBP_ASSERT(a_norm_nonzero, aclk, aresetn, state_reg == F_NORM |-> acc_reg != '0)
    // Encode commands carry a normalized value and a real exponent
    `GCBP_ASSERT(a_enc_normalized, aclk, aresetn, cmd_valid_reg && cmd_reg.op == gcbp_pkg::OP_ENCODE |-> cmd_reg.norm[VW-1] && cmd_reg.e != '0)

endmodule

>>> src/gcbp_fifo.sv
// ---------------------------------------------------------------------------
// gcbp_fifo
// Two-entry command queue between front and back, head always in slot 0.
// ---------------------------------------------------------------------------
module gcbp_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  gcbp_pkg::cmd_t  push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output gcbp_pkg::cmd_t  pop_data
);

    gcbp_pkg::cmd_t  slot0_reg, slot0_next;
    gcbp_pkg::cmd_t  slot1_reg, slot1_next;
    logic [1:0]      count_reg, count_next;

    logic            do_push, do_pop;
    logic [1:0]      wr_pos;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot0_reg;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Shift on pop, write behind the current tail
    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        wr_pos     = count_reg - {1'b0, do_pop};
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
        if (do_pop) begin
            slot0_next = slot1_reg;
        end
        if (do_push) begin
            if (wr_pos == 2'd0) begin
                slot0_next = push_data;
            end else begin
                slot1_next = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

>>> src/gcbp_back.sv
// ---------------------------------------------------------------------------
// gcbp_back
// Runs commands and drives the result register: packs code bits into bytes up
// to eight at a time, scans decode bytes one bit per cycle unless stalled.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gcbp_back #(
    parameter int MAX_EXPONENT = gcbp_pkg::MAX_EXPONENT_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  gcbp_pkg::cmd_t  cmd,
    output logic            m_valid,
    input  logic            m_ready,
    output gcbp_pkg::out_t  m_data
);

    localparam int OW  = $clog2(MAX_EXPONENT + 1);
    localparam int EW  = gcbp_pkg::EXP_W;
    localparam int LW  = gcbp_pkg::LEN_W;
    localparam int RW  = gcbp_pkg::REM_ACC_W;
    localparam int BW  = gcbp_pkg::BYTE_W;
    localparam int OVW = gcbp_pkg::OUT_VALUE_W;
    localparam int SW  = gcbp_pkg::VALUE_W + 1;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ERR,
        B_FLUSH,
        B_ONES,
        B_REM,
        B_DBIT,
        B_DCLOSE
    } bstate_t;

    bstate_t         state_reg, state_next;

    // result register
    logic            m_valid_reg, m_valid_next;
    gcbp_pkg::out_t  m_data_reg, m_data_next;

    // encoder architectural state
    logic [BW-1:0]   partial_reg, partial_next;
    logic [2:0]      filled_reg, filled_next;

    // encoder working registers
    logic [EW-1:0]   ones_left_reg, ones_left_next;
    logic [SW-1:0]   rem_sr_reg, rem_sr_next;
    logic [EW-1:0]   enc_rem_left_reg, enc_rem_left_next;
    logic [LW-1:0]   total_left_reg, total_left_next;
    logic [LW-1:0]   len_reg, len_next;

    // decoder architectural state
    logic            phase_reg, phase_next;
    logic [OW-1:0]   ones_reg, ones_next;
    logic [RW-1:0]   acc_reg, acc_next;
    logic [OW-1:0]   rleft_reg, rleft_next;

    // decoder working registers
    logic [BW-1:0]   byte_sr_reg, byte_sr_next;
    logic [2:0]      bit_cnt_reg, bit_cnt_next;
    logic            pend_valid_reg, pend_valid_next;
    gcbp_pkg::out_t  pend_reg, pend_next;

    logic            out_free;
    logic            push;
    gcbp_pkg::out_t  push_data;

    // packing datapath
    logic [3:0]      space;
    logic [EW-1:0]   src_left;
    logic [BW-1:0]   chunk;
    logic [3:0]      k;
    logic [2*BW-1:0] packed16;
    logic [3:0]      fill_sum;
    logic            byte_full;
    logic [LW-1:0]   total_after;

    // decode datapath
    logic            dbit;
    logic [RW-1:0]   acc_shift;
    logic [OW-1:0]   ones_m1;
    logic [OVW-1:0]  pow_val;
    logic [OVW-1:0]  dval;
    logic            d_res_valid;
    gcbp_pkg::out_t  d_res;
    logic            d_phase;
    logic [OW-1:0]   d_ones;
    logic [RW-1:0]   d_acc;
    logic [OW-1:0]   d_rleft;

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Chunk of code bits that fits the partial byte this cycle
    always_comb begin
        space = 4'd8 - {1'b0, filled_reg};
        if (state_reg == B_ONES) begin
            src_left = ones_left_reg;
            chunk    = '1;
        end else begin
            src_left = enc_rem_left_reg;
            chunk    = rem_sr_reg[SW-1 -: BW];
        end
        k           = ({{(EW-4){1'b0}}, space} < src_left) ? space : src_left[3:0];
        packed16    = {partial_reg, chunk} << k;
        fill_sum    = {1'b0, filled_reg} + k;
        byte_full   = (fill_sum == 4'd8);
        total_after = total_left_reg - LW'(k);
    end

    // One decode bit step
    always_comb begin
        dbit      = byte_sr_reg[BW-1];
        acc_shift = {acc_reg[RW-2:0], dbit};
        ones_m1   = ones_reg - OW'(1);
        for (int i = 0; i < OVW; i++) begin
            pow_val[i] = (i < (1 << OW)) && (ones_m1 == OW'(i));
        end
        dval = pow_val + {1'b0, acc_shift};

        d_res_valid = 1'b0;
        d_res       = '0;
        d_phase     = phase_reg;
        d_ones      = ones_reg;
        d_acc       = acc_reg;
        d_rleft     = rleft_reg;

        if (!phase_reg) begin
            if (dbit) begin
                if (ones_reg >= OW'(MAX_EXPONENT)) begin
                    // unary run too long: report and restart
                    d_res_valid       = 1'b1;
                    d_res.result_kind = gcbp_pkg::RK_ERROR;
                    d_ones            = '0;
                    d_acc             = '0;
                    d_rleft           = '0;
                end else begin
                    d_ones = ones_reg + OW'(1);
                end
            end else if (ones_reg == '0) begin
                // bare zero bit decodes to value zero
                d_res_valid       = 1'b1;
                d_res.result_kind = gcbp_pkg::RK_VALUE;
            end else begin
                d_phase = 1'b1;
                d_acc   = '0;
                d_rleft = ones_reg;
            end
        end else begin
            d_acc   = acc_shift;
            d_rleft = rleft_reg - OW'(1);
            if (rleft_reg == OW'(1)) begin
                d_res_valid       = 1'b1;
                d_res.result_kind = gcbp_pkg::RK_VALUE;
                d_res.out_value   = dval;
                d_phase           = 1'b0;
                d_ones            = '0;
                d_acc             = '0;
                d_rleft           = '0;
            end
        end
    end

    // Command sequencer
    always_comb begin
        state_next        = state_reg;
        m_valid_next      = m_valid_reg;
        m_data_next       = m_data_reg;
        partial_next      = partial_reg;
        filled_next       = filled_reg;
        ones_left_next    = ones_left_reg;
        rem_sr_next       = rem_sr_reg;
        enc_rem_left_next = enc_rem_left_reg;
        total_left_next   = total_left_reg;
        len_next          = len_reg;
        phase_next        = phase_reg;
        ones_next         = ones_reg;
        acc_next          = acc_reg;
        rleft_next        = rleft_reg;
        byte_sr_next      = byte_sr_reg;
        bit_cnt_next      = bit_cnt_reg;
        pend_valid_next   = pend_valid_reg;
        pend_next         = pend_reg;
        cmd_ready         = 1'b0;
        push              = 1'b0;
        push_data         = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            B_IDLE: begin
                if (cmd_valid) begin
                    cmd_ready = 1'b1;
                    case (cmd.op)
                        gcbp_pkg::OP_ENCODE: begin
                            ones_left_next    = cmd.e;
                            rem_sr_next       = {2'b00, cmd.norm[SW-3:0]};
                            enc_rem_left_next = cmd.e + EW'(1);
                            total_left_next   = {cmd.e, 1'b1};
                            len_next          = {cmd.e, 1'b1};
                            state_next        = B_ONES;
                        end
                        gcbp_pkg::OP_ERROR: begin
                            state_next = B_ERR;
                        end
                        gcbp_pkg::OP_ENC_FLUSH: begin
                            if (filled_reg != 3'd0) begin
                                state_next = B_FLUSH;
                            end else begin
                                partial_next = '0;
                                phase_next   = 1'b0;
                                ones_next    = '0;
                                acc_next     = '0;
                                rleft_next   = '0;
                            end
                        end
                        gcbp_pkg::OP_DEC_FLUSH: begin
                            partial_next = '0;
                            filled_next  = 3'd0;
                            phase_next   = 1'b0;
                            ones_next    = '0;
                            acc_next     = '0;
                            rleft_next   = '0;
                        end
                        gcbp_pkg::OP_DECODE: begin
                            byte_sr_next = cmd.in_byte;
                            bit_cnt_next = 3'd0;
                            state_next   = B_DBIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            B_ERR: begin
                if (out_free) begin
                    push                  = 1'b1;
                    push_data.result_kind = gcbp_pkg::RK_ERROR;
                    push_data.last        = 1'b1;
                    state_next            = B_IDLE;
                end
            end
            B_FLUSH: begin
                // zero padded tail byte, then clear all coder state
                if (out_free) begin
                    push                  = 1'b1;
                    push_data.result_kind = gcbp_pkg::RK_BYTE;
                    push_data.out_byte    = BW'(partial_reg << (4'd8 - {1'b0, filled_reg}));
                    push_data.last        = 1'b1;
                    partial_next          = '0;
                    filled_next           = 3'd0;
                    phase_next            = 1'b0;
                    ones_next             = '0;
                    acc_next              = '0;
                    rleft_next            = '0;
                    state_next            = B_IDLE;
                end
            end
            B_ONES, B_REM: begin
                if (!byte_full || out_free) begin
                    total_left_next = total_after;
                    if (byte_full) begin
                        push                  = 1'b1;
                        push_data.result_kind = gcbp_pkg::RK_BYTE;
                        push_data.out_byte    = packed16[2*BW-1:BW];
                        push_data.code_length = len_reg;
                        push_data.last        = (total_after < LW'(8));
                        partial_next          = '0;
                        filled_next           = 3'd0;
                    end else begin
                        partial_next = packed16[2*BW-1:BW];
                        filled_next  = fill_sum[2:0];
                    end
                    if (state_reg == B_ONES) begin
                        ones_left_next = ones_left_reg - EW'(k);
                        if (ones_left_reg == EW'(k)) begin
                            state_next = B_REM;
                        end
                    end else begin
                        rem_sr_next       = rem_sr_reg << k;
                        enc_rem_left_next = enc_rem_left_reg - EW'(k);
                        if (enc_rem_left_reg == EW'(k)) begin
                            state_next = B_IDLE;
                        end
                    end
                end
            end
            B_DBIT: begin
                // a new result pushes the held one out, last flag clear
                if (!(d_res_valid && pend_valid_reg) || out_free) begin
                    if (d_res_valid && pend_valid_reg) begin
                        push      = 1'b1;
                        push_data = pend_reg;
                    end
                    if (d_res_valid) begin
                        pend_valid_next = 1'b1;
                        pend_next       = d_res;
                    end
                    phase_next   = d_phase;
                    ones_next    = d_ones;
                    acc_next     = d_acc;
                    rleft_next   = d_rleft;
                    byte_sr_next = byte_sr_reg << 1;
                    bit_cnt_next = bit_cnt_reg + 3'd1;
                    if (bit_cnt_reg == 3'd7) begin
                        state_next = B_DCLOSE;
                    end
                end
            end
            B_DCLOSE: begin
                if (!pend_valid_reg) begin
                    state_next = B_IDLE;
                end else if (out_free) begin
                    push            = 1'b1;
                    push_data       = pend_reg;
                    push_data.last  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase

        if (push) begin
            m_valid_next = 1'b1;
            m_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= B_IDLE;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            partial_reg    <= '0;
            filled_reg     <= 3'd0;
            phase_reg      <= 1'b0;
            ones_reg       <= '0;
            acc_reg        <= '0;
            rleft_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
            partial_reg    <= partial_next;
            filled_reg     <= filled_next;
            phase_reg      <= phase_next;
            ones_reg       <= ones_next;
            acc_reg        <= acc_next;
            rleft_reg      <= rleft_next;
        end
        m_data_reg       <= m_data_next;
        ones_left_reg    <= ones_left_next;
        rem_sr_reg       <= rem_sr_next;
        enc_rem_left_reg <= enc_rem_left_next;
        total_left_reg   <= total_left_next;
        len_reg          <= len_next;
        byte_sr_reg      <= byte_sr_next;
        bit_cnt_reg      <= bit_cnt_next;
        pend_reg         <= pend_next;
    end

    // Bit budget of a value being packed matches its remaining pieces
    `GCBP_ASSERT(a_ones_budget, aclk, aresetn, state_reg == B_ONES |-> total_left_reg == LW'(ones_left_reg) + LW'(enc_rem_left_reg))
    `GCBP_ASSERT(a_rem_budget, aclk, aresetn, state_reg == B_REM |-> total_left_reg == LW'(enc_rem_left_reg))
    // Remainder phase always has bits to go
    `GCBP_ASSERT(a_phase_left, aclk, aresetn, phase_reg |-> rleft_reg != '0)
    // Held decode result never outlives its byte
    `GCBP_NEVER(a_idle_pend, aclk, aresetn, state_reg == B_IDLE && pend_valid_reg)

endmodule

>>> src/gamma_code_bit_packer.sv
// ---------------------------------------------------------------------------
// gamma_code_bit_packer
// Gamma-style variable-length coder over an MSB-first byte stream.
// ---------------------------------------------------------------------------
//  channel   | signals                     | direction | content
//  ----------+-----------------------------+-----------+------------------------
//  s_        | s_valid s_ready s_data      | in        | value or byte, end mark
//  m_        | m_valid m_ready m_data      | out       | byte, value or error
//  cfg_      | cfg_we cfg_wdata            | in        | direction register
//
//  Front: takes a new item only once the normalizer is idle and its command
//  register is empty; for an encode value the normalizer skips one zero
//  nibble per step until the top nibble is nonzero, then finishes the shift.
//  Encode back: a command step, then one step per chunk of up to 8 bits
//  that ends at a byte boundary or at the end of the ones or remainder bits.
//  Decode back: a command step, one step per bit, and a close step.
//  Reset clears the control and coder state; no clearing pass is needed.
//  A stalled result register holds the back; the front keeps taking items
//  until the two-entry command queue and its own command register fill.
// ---------------------------------------------------------------------------
module gamma_code_bit_packer #(
    parameter int MAX_EXPONENT = gcbp_pkg::MAX_EXPONENT_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic            cfg_wdata,
    input  logic            s_valid,
    output logic            s_ready,
    input  gcbp_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output gcbp_pkg::out_t  m_data
);

    logic            f_cmd_valid, f_cmd_ready;
    gcbp_pkg::cmd_t  f_cmd;
    logic            q_cmd_valid, q_cmd_ready;
    gcbp_pkg::cmd_t  q_cmd;

    // Classification and exponent search
    gcbp_front #(
        .MAX_EXPONENT (MAX_EXPONENT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (f_cmd_valid),
        .cmd_ready (f_cmd_ready),
        .cmd       (f_cmd)
    );

    // Command queue
    gcbp_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_cmd_valid),
        .push_ready (f_cmd_ready),
        .push_data  (f_cmd),
        .pop_valid  (q_cmd_valid),
        .pop_ready  (q_cmd_ready),
        .pop_data   (q_cmd)
    );

    // Bit packing, bit scanning and result register
    gcbp_back #(
        .MAX_EXPONENT (MAX_EXPONENT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_cmd_valid),
        .cmd_ready (q_cmd_ready),
        .cmd       (q_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
